// ----- design/rfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, codes and the byte-wide CRC-16/Kermit update for the radio
// frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

    // Frame layout.
    localparam int HEADER_BYTES = 7;
    localparam int CRC_BYTES    = 2;
    localparam int HDR_FIELDS   = 5;

    // CRC-16/Kermit: reflected polynomial, zero start value, no final xor.
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Header check flags.
    localparam logic [2:0] FLAG_MAGIC   = 3'b001;
    localparam logic [2:0] FLAG_VERSION = 3'b010;
    localparam logic [2:0] FLAG_LENGTH  = 3'b100;

    // Register reset values.
    localparam logic [7:0] MAGIC_RST   = 8'd0;
    localparam logic [7:0] VERSION_RST = 8'd1;
    localparam logic [7:0] MAX_LEN_RST = 8'd246;
    localparam logic [7:0] MIN_LEN_RST = 8'd9;

    // Saturation point of the byte counter.
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // Header field slots.
    typedef enum logic [2:0] {
        HF_TYPE = 3'd0,
        HF_SEQ  = 3'd1,
        HF_SRC  = 3'd2,
        HF_DST  = 3'd3,
        HF_LEN  = 3'd4
    } hdr_field_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_MAX_LEN = 2'd2,
        REG_MIN_LEN = 2'd3
    } reg_index_t;

    // End of packet status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_CRC_BAD   = 3'd6
    } status_t;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // One result word as held in the output queue.
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        status_t    status;
        logic [7:0] packet_type;
        logic [7:0] sequence_number;
        logic [7:0] source_address;
        logic [7:0] destination_address;
        logic [7:0] payload_length;
        logic       crc_ok;
        logic       last_result;
    } result_t;

    // Byte-wide CRC update, eight reflected shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/radio_frame_parser_crc16.sv -----
// ----------------------------------------------------------------------------
// radio_frame_parser_crc16
// Deframes a received radio buffer byte by byte and checks its CRC-16/Kermit.
// ----------------------------------------------------------------------------
// Bytes of a received buffer enter on the s_axis channel, one byte a word,
// with tlast on the final byte of the buffer. Results leave on m_axis: tuser
// is 0 for a payload byte and 1 for the end of packet status, and tlast
// marks the final result caused by one input byte.
// A byte is taken into an input register, then processed, once the queue
// has room, by the header checks and a byte-wide CRC update, and its results
// are written to a small output queue that is offered on m_axis. One byte is
// accepted every cycle while the queue has room; a final byte that is also a
// payload byte yields two results, which the queue absorbs.
// A byte is processed only when the queue has room for two results, so a
// stalled receiver fills the queue and then holds s_axis_tready low; no
// result is dropped. Configuration writes take effect at once; they are to
// be made only while the block is idle, which the block itself does not
// enforce.
// Reset clears the frame state, the queue and the input register, and
// loads the register defaults (magic 0, version 1, max length 246, min
// packet length 9).
// ----------------------------------------------------------------------------
module radio_frame_parser_crc16 #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Input bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status,
    // [26:19] packet_type, [34:27] sequence_number, [42:35] source_address,
    // [50:43] destination_address, [58:51] payload_length, [59] crc_ok,
    // [63:60] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_result
);
    import rfp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(FIFO_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Configuration registers.
    logic [7:0] magic_reg, version_reg, max_len_reg, min_len_reg;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Frame state.
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [7:0]  hdr_reg  [HDR_FIELDS];
    logic [7:0]  hdr_next [HDR_FIELDS];
    logic [2:0]  flags_reg, flags_next;

    // Output queue.
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg, wr_ptr_p1;
    logic [CNT_W-1:0]  count_reg;

    // Processing results.
    logic    proc_fire;
    logic    pay_emit;
    logic    stat_emit;
    result_t pay_res, stat_res;
    result_t wr0_res;
    logic [1:0] n_wr;
    logic    rd_fire;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RST;
            version_reg <= VERSION_RST;
            max_len_reg <= MAX_LEN_RST;
            min_len_reg <= MIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_VERSION: version_reg <= cfg_data;
                REG_MAX_LEN: max_len_reg <= cfg_data;
                REG_MIN_LEN: min_len_reg <= cfg_data;
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    // A byte is processed only when the queue can take two results.
    assign proc_fire     = in_vld_reg && (count_reg <= ROOM_MAX);
    assign s_axis_tready = !in_vld_reg || proc_fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Per-byte header checks, CRC update and result formation.
    always_comb
    begin
        logic [7:0] pos;
        logic [8:0] hdr_end;
        logic [9:0] frame_need;
        logic [2:0] slot;
        status_t    st;

        pos        = byte_count_reg;
        hdr_end    = {1'b0, hdr_reg[HF_LEN]} + 9'(HEADER_BYTES);
        slot       = pos[2:0] - 3'd2;

        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        hdr_next          = hdr_reg;
        flags_next        = flags_reg;
        pay_emit          = 1'b0;

        if (pos != COUNT_MAX)
        begin
            if (pos == 8'd0 && in_byte_reg != magic_reg)
            begin
                flags_next = flags_next | FLAG_MAGIC;
            end
            if (pos == 8'd1 && in_byte_reg != version_reg)
            begin
                flags_next = flags_next | FLAG_VERSION;
            end
            if (pos >= 8'd2 && pos < 8'(HEADER_BYTES))
            begin
                hdr_next[slot] = in_byte_reg;
            end
            if (pos == 8'(HEADER_BYTES - 1) && in_byte_reg > max_len_reg)
            begin
                flags_next = flags_next | FLAG_LENGTH;
            end

            // CRC covers header and payload; the two bytes after it are the
            // received CRC, low byte first.
            if ({1'b0, pos} < hdr_end)
            begin
                running_crc_next = crc_byte(running_crc_reg, in_byte_reg);
            end
            else if ({1'b0, pos} == hdr_end)
            begin
                received_crc_next = {received_crc_reg[15:8], in_byte_reg};
            end
            else if ({1'b0, pos} == hdr_end + 9'd1)
            begin
                received_crc_next = {in_byte_reg, received_crc_reg[7:0]};
            end

            pay_emit = (pos >= 8'(HEADER_BYTES)) && ({1'b0, pos} < hdr_end)
                       && (flags_reg == 3'b000);
            byte_count_next = byte_count_reg + 8'd1;
        end

        // Payload result.
        pay_res               = '0;
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload_byte  = in_byte_reg;
        pay_res.payload_index = pos - 8'(HEADER_BYTES);
        pay_res.status        = ST_OK;
        pay_res.last_result   = !in_last_reg;

        // Status: the first failing check wins.
        frame_need = {2'b00, hdr_next[HF_LEN]} + 10'(HEADER_BYTES + CRC_BYTES);
        if (byte_count_next < min_len_reg)
            st = ST_SHORT;
        else if ((flags_next & FLAG_MAGIC) != 3'b000)
            st = ST_MAGIC;
        else if ((flags_next & FLAG_VERSION) != 3'b000)
            st = ST_VERSION;
        else if (hdr_next[HF_LEN] > max_len_reg)
            st = ST_TOO_LONG;
        else if ({2'b00, byte_count_next} < frame_need)
            st = ST_TRUNCATED;
        else if (received_crc_next != running_crc_next)
            st = ST_CRC_BAD;
        else
            st = ST_OK;

        stat_res                     = '0;
        stat_res.kind                = KIND_STATUS;
        stat_res.status              = st;
        stat_res.packet_type         = hdr_next[HF_TYPE];
        stat_res.sequence_number     = hdr_next[HF_SEQ];
        stat_res.source_address      = hdr_next[HF_SRC];
        stat_res.destination_address = hdr_next[HF_DST];
        stat_res.payload_length      = hdr_next[HF_LEN];
        stat_res.crc_ok              = (st == ST_OK);
        stat_res.last_result         = 1'b1;

        stat_emit = in_last_reg;
    end

    // Frame state; everything clears after the final byte of a buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            running_crc_reg  <= CRC_INIT;
            received_crc_reg <= '0;
            flags_reg        <= '0;
            for (int i = 0; i < HDR_FIELDS; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                byte_count_reg   <= '0;
                running_crc_reg  <= CRC_INIT;
                received_crc_reg <= '0;
                flags_reg        <= '0;
                for (int i = 0; i < HDR_FIELDS; i++)
                begin
                    hdr_reg[i] <= '0;
                end
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                running_crc_reg  <= running_crc_next;
                received_crc_reg <= received_crc_next;
                flags_reg        <= flags_next;
                hdr_reg          <= hdr_next;
            end
        end
    end

    // Queue write selection: payload first, status behind it.
    assign n_wr      = proc_fire ? ({1'b0, pay_emit} + {1'b0, stat_emit}) : 2'd0;
    assign wr0_res   = pay_emit ? pay_res : stat_res;
    assign wr_ptr_p1 = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_fire   = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= wr0_res;
        end
        if (n_wr == 2'd2)
        begin
            fifo_mem[wr_ptr_p1] <= stat_res;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (n_wr == 2'd1)
            begin
                wr_ptr_reg <= wr_ptr_p1;
            end
            else if (n_wr == 2'd2)
            begin
                wr_ptr_reg <= (wr_ptr_p1 == LAST_IDX) ? '0 : wr_ptr_p1 + PTR_W'(1);
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(n_wr) - CNT_W'(rd_fire);
        end
    end

    // Output channel.
    result_t head;
    assign head          = fifo_mem[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last_result;
    assign m_axis_tdata  = {4'b0000, head.crc_ok, head.payload_length,
                            head.destination_address, head.source_address,
                            head.sequence_number, head.packet_type,
                            head.status, head.payload_index, head.payload_byte};

    // The queue never overfills.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overflow");

    // A final byte always leaves the frame state cleared.
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_last_reg) |=> (byte_count_reg == 8'd0 && flags_reg == 3'b000))
        else $error("frame state not cleared after final byte");

    // A payload result never reports a good CRC.
    a_payload_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |-> !m_axis_tdata[59])
        else $error("payload result carries crc_ok");

    // A byte waiting in the input register is processed once the queue drains.
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && count_reg == '0) |-> proc_fire)
        else $error("input stuck with empty queue");

endmodule
